// ===== design/tmgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tmgr_pkg
// Shared types and constants for the text-mode glyph renderer: channel
// payloads, the command record that crosses the front/back queue, and the
// back-end sequencer states.
// ----------------------------------------------------------------------------
package tmgr_pkg;

    // Screen and font geometry.
    localparam int GLYPH_COUNT  = 64;
    localparam int SCREEN_PITCH = 320;
    localparam int GLYPH_ROWS   = 7;
    localparam int FONT_DEPTH   = GLYPH_COUNT * 8;
    localparam int FONT_AW      = $clog2(FONT_DEPTH);
    localparam int GLYPH_BITS   = $clog2(GLYPH_COUNT);
    localparam int ROW_CNT_W    = 3;
    localparam int LINE_CHARS   = 40;
    localparam int CHAR_WIDTH   = 7;
    localparam int LEFT_MARGIN  = 20;
    localparam int TOP_MARGIN   = 24;
    localparam int FB_W         = 17;
    localparam int X_W          = 9;
    localparam int Y_W          = 8;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    // Character byte folding.
    localparam logic [5:0] GLYPH_FOLD_XOR = 6'h20;

    // Function codes of an incoming request.
    localparam logic FUNC_TEXT = 1'b0;
    localparam logic FUNC_FONT = 1'b1;

    // Incoming request.
    typedef struct packed {
        logic       func;
        logic [9:0] address;
        logic [7:0] data;
        logic [8:0] font_index;
        logic [7:0] font_byte;
    } tmgr_req_t;

    // Outgoing glyph row.
    typedef struct packed {
        logic [16:0] fb_offset;
        logic [5:0]  pixel_mask;
        logic        row_last;
    } tmgr_row_t;

    // Decoded request held in the front stage.
    typedef struct packed {
        logic                  func;
        logic                  hole;
        logic [X_W-1:0]        x;
        logic [Y_W-1:0]        y;
        logic [GLYPH_BITS-1:0] glyph;
        logic                  inv;
        logic [8:0]            font_index;
        logic [7:0]            font_byte;
    } tmgr_front_t;

    // Command passed from front to back.
    typedef struct packed {
        logic                  is_load;
        logic                  load_en;
        logic [FONT_AW-1:0]    font_addr;
        logic [7:0]            font_byte;
        logic [GLYPH_BITS-1:0] glyph;
        logic                  inv;
        logic [FB_W-1:0]       fb_base;
    } tmgr_cmd_t;

    // Back-end sequencer states.
    typedef enum logic [0:0] {
        BK_IDLE,
        BK_DRAW
    } tmgr_bk_state_t;

endpackage

// ===== design/tmgr_front.sv =====
// ----------------------------------------------------------------------------
// tmgr_front
// Accepts requests, maps text addresses to screen row and column, folds the
// character byte to a glyph code and pushes commands into the queue. Writes
// that fall in the unused tail of a 128-byte block are dropped here.
// ----------------------------------------------------------------------------
module tmgr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tmgr_pkg::tmgr_req_t cmd,
    output logic                push,
    output tmgr_pkg::tmgr_cmd_t push_data,
    input  logic                q_full
);

    logic                  fr_valid_reg;
    logic                  fr_valid_next;
    tmgr_pkg::tmgr_front_t fr_reg;
    tmgr_pkg::tmgr_front_t fr_next;
    logic                  accept;
    logic                  drain;
    logic [6:0]            blk_off;
    logic [1:0]            band;
    logic [6:0]            col_wide;
    logic [4:0]            row;
    logic [31:0]           x_wide;
    logic [31:0]           y_wide;
    logic [31:0]           base_wide;

    // The stage empties when the queue has room.
    assign drain     = fr_valid_reg && !q_full;
    assign cmd_stall = fr_valid_reg && q_full;
    assign accept    = cmd_valid && !cmd_stall;

    // Interleaved layout: each 128-byte block holds three 40-byte bands.
    assign blk_off = cmd.address[6:0];

    always_comb
    begin
        if (blk_off < 7'(tmgr_pkg::LINE_CHARS)) begin
            band     = 2'd0;
            col_wide = blk_off;
        end else if (blk_off < 7'(2 * tmgr_pkg::LINE_CHARS)) begin
            band     = 2'd1;
            col_wide = blk_off - 7'(tmgr_pkg::LINE_CHARS);
        end else if (blk_off < 7'(3 * tmgr_pkg::LINE_CHARS)) begin
            band     = 2'd2;
            col_wide = blk_off - 7'(2 * tmgr_pkg::LINE_CHARS);
        end else begin
            band     = 2'd3;
            col_wide = 7'd0;
        end
    end

    assign row    = {band, cmd.address[9:7]};
    assign x_wide = 32'(col_wide) * 32'(tmgr_pkg::CHAR_WIDTH)
                    + 32'(tmgr_pkg::LEFT_MARGIN);
    assign y_wide = 32'(row) * 32'd8 + 32'(tmgr_pkg::TOP_MARGIN);

    // Decode the incoming request.
    always_comb
    begin
        fr_next.func       = cmd.func;
        fr_next.hole       = (band == 2'd3);
        fr_next.x          = x_wide[tmgr_pkg::X_W-1:0];
        fr_next.y          = y_wide[tmgr_pkg::Y_W-1:0];
        fr_next.glyph      = tmgr_pkg::GLYPH_BITS'(cmd.data[5:0] ^ tmgr_pkg::GLYPH_FOLD_XOR);
        fr_next.inv        = !cmd.data[7];
        fr_next.font_index = cmd.font_index;
        fr_next.font_byte  = cmd.font_byte;
    end

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (drain) begin
            fr_valid_next = 1'b0;
        end
        if (accept) begin
            fr_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            fr_reg <= fr_next;
        end
    end

    // Frame-buffer offset of the glyph's top row.
    assign base_wide = 32'(fr_reg.x) + 32'(fr_reg.y) * 32'(tmgr_pkg::SCREEN_PITCH);

    // Build the queue command; visible writes and font loads go through.
    always_comb
    begin
        push_data.is_load   = (fr_reg.func == tmgr_pkg::FUNC_FONT);
        push_data.load_en   = (32'(fr_reg.font_index) < 32'(tmgr_pkg::FONT_DEPTH));
        push_data.font_addr = tmgr_pkg::FONT_AW'(fr_reg.font_index);
        push_data.font_byte = fr_reg.font_byte;
        push_data.glyph     = fr_reg.glyph;
        push_data.inv       = fr_reg.inv;
        push_data.fb_base   = base_wide[tmgr_pkg::FB_W-1:0];
        push = drain && (fr_reg.func == tmgr_pkg::FUNC_FONT || !fr_reg.hole);
    end

endmodule

// ===== design/tmgr_queue.sv =====
// ----------------------------------------------------------------------------
// tmgr_queue
// Small first-in first-out command queue that decouples the front stage
// from the glyph sequencer.
// ----------------------------------------------------------------------------
module tmgr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tmgr_pkg::tmgr_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output tmgr_pkg::tmgr_cmd_t pop_data,
    output logic                empty
);

    tmgr_pkg::tmgr_cmd_t               slot_reg [tmgr_pkg::QUEUE_DEPTH];
    logic [tmgr_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [tmgr_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [tmgr_pkg::QUEUE_AW:0]       count_reg;
    logic [tmgr_pkg::QUEUE_AW:0]       count_next;

    assign full     = (count_reg == (tmgr_pkg::QUEUE_AW+1)'(tmgr_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/tmgr_back.sv =====
// ----------------------------------------------------------------------------
// tmgr_back
// Glyph sequencer. Owns the font store, applies font loads and walks the
// seven glyph rows of each draw command through a read stage and an output
// register, one font read per cycle while a row stall does not hold it.
// ----------------------------------------------------------------------------
module tmgr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tmgr_pkg::tmgr_cmd_t head,
    input  logic                q_empty,
    output logic                pop,
    output logic                row_valid,
    input  logic                row_stall,
    output tmgr_pkg::tmgr_row_t row
);

    logic [7:0]                       font_mem [tmgr_pkg::FONT_DEPTH];
    tmgr_pkg::tmgr_bk_state_t         state_reg;
    tmgr_pkg::tmgr_bk_state_t         state_next;
    logic [tmgr_pkg::ROW_CNT_W-1:0]   row_cnt_reg;
    logic [tmgr_pkg::GLYPH_BITS-1:0]  glyph_reg;
    logic                             inv_reg;
    logic [tmgr_pkg::FB_W-1:0]        off_reg;
    logic                             s1_valid_reg;
    logic [7:0]                       s1_data_reg;
    logic [tmgr_pkg::FB_W-1:0]        s1_off_reg;
    logic                             s1_inv_reg;
    logic                             s1_last_reg;
    logic                             row_valid_reg;
    tmgr_pkg::tmgr_row_t              row_reg;
    logic                             adv;
    logic                             issue;
    logic                             last_row;
    logic                             take;
    logic                             take_draw;
    logic                             mem_we;

    // The output register frees when empty or when its row is taken.
    assign adv      = !row_valid_reg || !row_stall;
    assign last_row = (row_cnt_reg == tmgr_pkg::ROW_CNT_W'(tmgr_pkg::GLYPH_ROWS - 1));

    // Sequencer: next state and per-cycle controls.
    always_comb
    begin
        state_next = state_reg;
        issue      = 1'b0;
        take       = 1'b0;
        unique case (state_reg)
            tmgr_pkg::BK_IDLE:
            begin
                take = !q_empty;
            end
            tmgr_pkg::BK_DRAW:
            begin
                issue = !s1_valid_reg || adv;
                if (issue && last_row) begin
                    state_next = tmgr_pkg::BK_IDLE;
                    take       = !q_empty;
                end
            end
            default:
            begin
                state_next = tmgr_pkg::BK_IDLE;
            end
        endcase
        if (take) begin
            state_next = head.is_load ? tmgr_pkg::BK_IDLE : tmgr_pkg::BK_DRAW;
        end
        take_draw = take && !head.is_load;
        mem_we    = take && head.is_load && head.load_en;
        pop       = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= tmgr_pkg::BK_IDLE;
            row_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            row_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (take_draw) begin
                row_cnt_reg <= '0;
            end else if (issue) begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
            if (issue) begin
                s1_valid_reg <= 1'b1;
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv) begin
                row_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Per-draw context; the offset steps one pitch per issued row.
    always_ff @(posedge clk)
    begin
        if (take_draw) begin
            glyph_reg <= head.glyph;
            inv_reg   <= head.inv;
            off_reg   <= head.fb_base;
        end else if (issue) begin
            off_reg <= off_reg + tmgr_pkg::FB_W'(tmgr_pkg::SCREEN_PITCH);
        end
    end

    // Font store: one write port for loads, one registered read port for rows.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            font_mem[head.font_addr] <= head.font_byte;
        end
        if (issue) begin
            s1_data_reg <= font_mem[{glyph_reg, row_cnt_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue) begin
            s1_off_reg  <= off_reg;
            s1_inv_reg  <= inv_reg;
            s1_last_reg <= last_row;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv) begin
            row_reg.fb_offset  <= s1_off_reg;
            row_reg.pixel_mask <= s1_data_reg[7:2] ^ {6{s1_inv_reg}};
            row_reg.row_last   <= s1_last_reg;
        end
    end

    assign row_valid = row_valid_reg;
    assign row       = row_reg;

endmodule

// ===== design/text_mode_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// text_mode_glyph_renderer
// Renders writes to a 40x24 interleaved text screen as seven glyph rows of
// frame-buffer offset and pixel mask, using a loadable 64-glyph font store.
//
//   Channel   Dir   Handshake               Payload
//   cmd       in    cmd_valid / cmd_stall   tmgr_req_t (text write, font load)
//   row       out   row_valid / row_stall   tmgr_row_t (one glyph row)
//
// A visible text write occupies the glyph sequencer for one font store read
// per row; a font load is applied as the sequencer takes it, and a write into
// an unused address never reaches it. The front stage and a 4-entry command
// queue let requests keep arriving while rows are drawn. Reset clears all
// control state; the font store is not cleared. A stall on the row channel
// holds the sequencer only once its read stage and output register are full.
// ----------------------------------------------------------------------------
module text_mode_glyph_renderer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tmgr_pkg::tmgr_req_t cmd,
    output logic                row_valid,
    input  logic                row_stall,
    output tmgr_pkg::tmgr_row_t row
);

    logic                push;
    tmgr_pkg::tmgr_cmd_t push_data;
    logic                q_full;
    logic                q_empty;
    logic                pop;
    tmgr_pkg::tmgr_cmd_t head;

    // Request decode.
    tmgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // Command queue.
    tmgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (q_empty)
    );

    // Glyph sequencer and font store.
    tmgr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .row_valid (row_valid),
        .row_stall (row_stall),
        .row       (row)
    );

endmodule

// ===== design/tmgr_checker.sv =====
// ----------------------------------------------------------------------------
// tmgr_checker
// Port-level checks for the glyph renderer, attached to the top level.
// ----------------------------------------------------------------------------
module tmgr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input tmgr_pkg::tmgr_req_t cmd,
    input logic                row_valid,
    input logic                row_stall,
    input tmgr_pkg::tmgr_row_t row
);

    // A stalled row stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_stall |=> row_valid)
        else $error("row_valid dropped while stalled");

    // A stalled row keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_stall |=> $stable(row))
        else $error("row payload changed while stalled");

    // Rows of one glyph follow each other one pitch apart.
    assert property (@(posedge clk) disable iff (!rst_n)
        (row_valid && !row_stall && !row.row_last) ##1 row_valid |->
        row.fb_offset == 17'($past(row.fb_offset) + 17'(tmgr_pkg::SCREEN_PITCH)))
        else $error("glyph row offset did not step by one pitch");

    // The input only starts stalling right after it took a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_stall) |-> $past(cmd_valid && !cmd_stall))
        else $error("cmd_stall rose without a preceding request");

endmodule

bind text_mode_glyph_renderer tmgr_checker u_tmgr_checker (.*);

// ===== verif/tb_text_mode_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// tb_text_mode_glyph_renderer
// Self-checking testbench for the text-mode glyph renderer. It loads the font
// rows of a chosen set of glyphs, drives directed screen-corner and
// font-extreme requests, then random text writes, hole writes and font
// reloads. Text writes only use glyphs whose rows have been loaded. Bursty
// sender gaps and a stall pattern on the row channel are applied in most tests.
// A local glyph-row predictor queues the seven rows of each visible write, and
// every accepted row is compared field by field against the oldest queued row.
// ----------------------------------------------------------------------------
module tb_text_mode_glyph_renderer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 20;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    tmgr_pkg::tmgr_req_t cmd_req   = '0;
    logic                row_valid;
    logic                row_stall = 1'b0;
    tmgr_pkg::tmgr_row_t row_out;

    // Predictor state: shadow of the font store and queued glyph rows.
    logic [7:0]          font_shadow [tmgr_pkg::FONT_DEPTH];
    tmgr_pkg::tmgr_row_t glyph_rows_due[$];
    tmgr_pkg::tmgr_row_t due_row;

    // Sender and receiver idle controls.
    int unsigned burst_left = 0;
    int unsigned gap_max    = 0;
    logic        stall_on   = 1'b0;
    int unsigned stall_max  = 3;
    int unsigned stall_left = 0;
    int unsigned free_left  = 0;

    // Run statistics.
    int unsigned cycle_count  = 0;
    int unsigned fail_count   = 0;
    int unsigned text_draws   = 0;
    int unsigned hole_writes  = 0;
    int unsigned font_loads   = 0;
    int unsigned rows_checked = 0;

    text_mode_glyph_renderer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd_req),
        .row_valid (row_valid),
        .row_stall (row_stall),
        .row       (row_out)
    );

    // Clock generation.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Row channel stall pattern: stall runs alternate with free runs.
    always @(posedge clk)
    begin
        if (!stall_on)
        begin
            row_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            row_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left != 0)
        begin
            row_stall <= 1'b0;
            free_left--;
        end
        else
        begin
            row_stall <= 1'b1;
            stall_left = $urandom_range(stall_max, 1) - 1;
            free_left  = $urandom_range(6, 1);
        end
    end

    // Row checker: each accepted row against the oldest predicted row.
    always @(posedge clk)
    begin
        if (rst_n && row_valid && !row_stall)
        begin
            if (glyph_rows_due.size() == 0)
            begin
                $display("%0t: unexpected row fb_offset %0d mask %b last %0d",
                         $time, row_out.fb_offset, row_out.pixel_mask,
                         row_out.row_last);
                fail_count++;
            end
            else
            begin
                due_row = glyph_rows_due.pop_front();
                rows_checked++;
                if (row_out.fb_offset !== due_row.fb_offset)
                begin
                    $display("%0t: fb_offset expected %0d actual %0d",
                             $time, due_row.fb_offset, row_out.fb_offset);
                    fail_count++;
                end
                if (row_out.pixel_mask !== due_row.pixel_mask)
                begin
                    $display("%0t: pixel_mask expected %b actual %b",
                             $time, due_row.pixel_mask, row_out.pixel_mask);
                    fail_count++;
                end
                if (row_out.row_last !== due_row.row_last)
                begin
                    $display("%0t: row_last expected %0d actual %0d",
                             $time, due_row.row_last, row_out.row_last);
                    fail_count++;
                end
            end
        end
    end

    // Glyph-row predictor: updates the font shadow or queues seven rows.
    task automatic predict_glyph_rows(input tmgr_pkg::tmgr_req_t req);
        int unsigned         offs;
        int unsigned         band;
        int unsigned         line;
        int unsigned         column;
        int unsigned         px;
        int unsigned         py;
        int unsigned         entry;
        logic [5:0]          glyph;
        logic [5:0]          invert;
        tmgr_pkg::tmgr_row_t r;
        if (req.func == tmgr_pkg::FUNC_FONT)
        begin
            if (req.font_index < tmgr_pkg::FONT_DEPTH)
                font_shadow[req.font_index] = req.font_byte;
            font_loads++;
            return;
        end
        // Interleaved layout: three 40-byte bands per 128-byte block.
        offs = req.address[6:0];
        band = offs / tmgr_pkg::LINE_CHARS;
        if (band > 2)
        begin
            hole_writes++;
            return;
        end
        line   = req.address[9:7] + band * 8;
        column = offs - band * tmgr_pkg::LINE_CHARS;
        glyph  = req.data[5:0] ^ tmgr_pkg::GLYPH_FOLD_XOR;
        invert = req.data[7] ? 6'h00 : 6'h3F;
        px     = column * tmgr_pkg::CHAR_WIDTH + tmgr_pkg::LEFT_MARGIN;
        py     = line * 8 + tmgr_pkg::TOP_MARGIN;
        for (int g = 0; g < tmgr_pkg::GLYPH_ROWS; g++)
        begin
            entry        = glyph * 8 + g;
            r.fb_offset  = 17'(px + (py + g) * tmgr_pkg::SCREEN_PITCH);
            r.pixel_mask = font_shadow[entry][7:2] ^ invert;
            r.row_last   = (g == tmgr_pkg::GLYPH_ROWS - 1);
            glyph_rows_due.push_back(r);
        end
        text_draws++;
    endtask

    // Sends one request, with bursts and random gaps when gaps are enabled.
    task automatic send_req(input tmgr_pkg::tmgr_req_t req);
        if (gap_max != 0 && burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge clk);
            burst_left = $urandom_range(8, 1);
        end
        cmd_req   <= req;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        predict_glyph_rows(req);
        if (burst_left != 0)
            burst_left--;
    endtask

    // Text write; the font fields are don't-care and carry noise.
    function automatic tmgr_pkg::tmgr_req_t text_req(input logic [9:0] addr,
                                                     input logic [7:0] chr);
        tmgr_pkg::tmgr_req_t req;
        req.func       = tmgr_pkg::FUNC_TEXT;
        req.address    = addr;
        req.data       = chr;
        req.font_index = 9'($urandom);
        req.font_byte  = 8'($urandom);
        return req;
    endfunction

    // Font load; the text fields are don't-care and carry noise.
    function automatic tmgr_pkg::tmgr_req_t font_req(input logic [8:0] idx,
                                                     input logic [7:0] bits);
        tmgr_pkg::tmgr_req_t req;
        req.func       = tmgr_pkg::FUNC_FONT;
        req.address    = 10'($urandom);
        req.data       = 8'($urandom);
        req.font_index = idx;
        req.font_byte  = bits;
        return req;
    endfunction

    // Glyphs whose seven font rows are loaded before any text write uses them.
    function automatic logic glyph_loaded(input logic [5:0] g);
        return (g < 6'd4) || (g >= 6'd28 && g < 6'd36) ||
               (g >= 6'd52 && g < 6'd56) || (g >= 6'd60);
    endfunction

    // Character byte that folds to a loaded glyph, with random attribute bits.
    function automatic logic [7:0] loaded_char();
        logic [5:0] g;
        g = 6'($urandom);
        while (!glyph_loaded(g))
            g = 6'($urandom);
        return {2'($urandom), g ^ tmgr_pkg::GLYPH_FOLD_XOR};
    endfunction

    // Stops sending and waits until every predicted row has arrived.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (glyph_rows_due.size() != 0) @(posedge clk);
    endtask

    // Loads the rows of every glyph that text writes are allowed to use.
    task automatic test_font_fill();
        gap_max  = 4;
        stall_on = 1'b0;
        for (int g = 0; g < tmgr_pkg::GLYPH_COUNT; g++)
        begin
            if (glyph_loaded(6'(g)))
            begin
                for (int k = 0; k < tmgr_pkg::GLYPH_ROWS; k++)
                    send_req(font_req(9'(g * 8 + k), 8'($urandom)));
            end
        end
    endtask

    // Font byte extremes on glyph 0 and glyph 63, drawn normal and inverse.
    task automatic test_font_extremes();
        logic [7:0] patterns [7] = '{8'h00, 8'hFF, 8'h80, 8'h03, 8'hFC, 8'h55, 8'hAA};
        gap_max  = 3;
        stall_on = 1'b1;
        for (int i = 0; i < tmgr_pkg::GLYPH_ROWS; i++)
            send_req(font_req(9'(i), patterns[i]));
        send_req(font_req(9'd504, 8'h00));
        send_req(font_req(9'd510, 8'hFF));
        send_req(font_req(9'd511, 8'hFF));
        send_req(text_req(10'd0, 8'hA0));
        send_req(text_req(10'd1, 8'h20));
        send_req(text_req(10'd2, 8'h9F));
        send_req(text_req(10'd3, 8'h1F));
    endtask

    // Screen corners, band edges, holes and character byte extremes.
    task automatic test_screen_corners();
        logic [9:0] addrs [10] = '{10'd0, 10'd39, 10'd40, 10'd80, 10'd119,
                                   10'd120, 10'd896, 10'd1015, 10'd1023, 10'd1000};
        logic [7:0] chars [10] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'hC1,
                                   8'h41, 8'h3F, 8'hA0, 8'h55, 8'hE0};
        gap_max  = 2;
        stall_on = 1'b1;
        for (int i = 0; i < 10; i++)
            send_req(text_req(addrs[i], chars[i]));
    endtask

    // Mostly visible writes, some hole writes and font reloads.
    task automatic test_random_traffic(input int unsigned count, input int unsigned gaps,
                                       input logic stalls, input int unsigned stall_len);
        int unsigned pick;
        logic [9:0]  addr;
        gap_max   = gaps;
        stall_on  = stalls;
        stall_max = stall_len;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 75)
            begin
                addr = {3'($urandom), 7'($urandom_range(119, 0))};
                send_req(text_req(addr, loaded_char()));
            end
            else if (pick < 83)
            begin
                addr = {3'($urandom), 7'($urandom_range(127, 120))};
                send_req(text_req(addr, 8'($urandom)));
            end
            else
            begin
                send_req(font_req(9'($urandom), 8'($urandom)));
            end
        end
    endtask

    // The sender holds off until every row is out, several times over.
    task automatic test_drain_pause();
        gap_max  = 0;
        stall_on = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 8; i++)
                send_req(text_req({3'($urandom), 7'($urandom_range(119, 0))},
                                  loaded_char()));
            wait_drained();
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_font_fill();
        test_font_extremes();
        test_screen_corners();
        test_random_traffic(45, 6, 1'b1, 3);
        test_random_traffic(25, 0, 1'b0, 1);
        test_drain_pause();
        test_random_traffic(45, 12, 1'b1, 8);

        wait_drained();
        stall_on = 1'b0;
        repeat (SETTLE_TICKS) @(posedge clk);
        if (glyph_rows_due.size() != 0)
        begin
            $display("%0t: %0d predicted rows never arrived", $time, glyph_rows_due.size());
            fail_count++;
        end

        $display("Covered %0d glyph draws, %0d hole writes and %0d font loads,",
                 text_draws, hole_writes, font_loads);
        $display("with %0d rows compared and %0d mismatches.", rows_checked, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tmgr_pkg.sv
design/tmgr_front.sv
design/tmgr_queue.sv
design/tmgr_back.sv
design/text_mode_glyph_renderer.sv
design/tmgr_checker.sv
verif/tb_text_mode_glyph_renderer.sv
